// File: rtl/fcsp_pkg.sv
// ----------------------------------------------------------------------------
// fcsp_pkg
// Shared types, constants and pulse-width conversions for the four-channel
// servo pulse generator.
// ----------------------------------------------------------------------------
package fcsp_pkg;

    localparam int FRAME_TICKS_DEF  = 2000;
    localparam int NUM_CHANNELS_DEF = 4;

    localparam int POS_W      = 11;
    localparam int WIDTH_W    = 8;
    localparam int CHANNEL_W  = 8;
    localparam int AMOUNT_W   = 16;
    localparam int OP_W       = 2;
    localparam int OUT_FIELDS = 4;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;

    localparam int MIN_US        = 500;
    localparam int MAX_US        = 2500;
    localparam int US_PER_TICK   = 10;
    localparam int MAX_ANGLE     = 180;
    localparam int RESET_WIDTH   = 150;
    localparam int MIN_TICKS     = MIN_US / US_PER_TICK;

    // floor(x / 10) for x <= 2500 and floor(x / 9) for x <= 1800
    localparam int RECIP_10 = 6554;
    localparam int RECIP_9  = 7282;

    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 2'd0,
        OP_SET_US    = 2'd1,
        OP_SET_ANGLE = 2'd2
    } t_op;

    function automatic logic [WIDTH_W-1:0] us_to_ticks(input logic [AMOUNT_W-1:0] amount);
        logic [11:0] us;
        logic [24:0] prod;
        if (amount < AMOUNT_W'(MIN_US)) begin
            us = 12'(MIN_US);
        end else if (amount > AMOUNT_W'(MAX_US)) begin
            us = 12'(MAX_US);
        end else begin
            us = amount[11:0];
        end
        prod = 25'(us) * 25'(RECIP_10);
        return prod[23:16];
    endfunction

    // 500 + a*2000/180 us, then /10: 50 + floor(a*10/9) ticks
    function automatic logic [WIDTH_W-1:0] angle_to_ticks(input logic [AMOUNT_W-1:0] amount);
        logic [7:0]  angle;
        logic [10:0] scaled;
        logic [23:0] prod;
        if (amount > AMOUNT_W'(MAX_ANGLE)) begin
            angle = 8'(MAX_ANGLE);
        end else begin
            angle = amount[7:0];
        end
        scaled = (11'(angle) << 3) + (11'(angle) << 1);
        prod   = 24'(scaled) * 24'(RECIP_9);
        return WIDTH_W'(MIN_TICKS) + prod[23:16];
    endfunction

endpackage

// File: rtl/four_channel_servo_pwm.sv
// ----------------------------------------------------------------------------
// four_channel_servo_pwm
// Servo pulse generator: ticks advance a frame counter, set items store a
// channel's pulse width; every item returns the channel levels.
//
//   Port group   Direction  tdata                         tuser
//   s_axis       in         channel[7:0], amount[23:8]    op[1:0]
//   m_axis       out        level_0..level_3 [3:0], 0s    -
//
// One item per clock while m_axis accepts; each item passes the input
// register, then the state update into the result register.
// Conversions are constant-reciprocal multiplies in the update stage.
// Sync reset clears the frame counter and levels and sets every width to 150.
// A stall on m_axis holds both stages; s_axis_tready follows the free slot.
// ----------------------------------------------------------------------------
module four_channel_servo_pwm #(
    parameter int FRAME_TICKS  = fcsp_pkg::FRAME_TICKS_DEF,
    parameter int NUM_CHANNELS = fcsp_pkg::NUM_CHANNELS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [fcsp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // channel, amount
    input  logic [fcsp_pkg::OP_W-1:0]          s_axis_tuser,  // op
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [fcsp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // level_0..level_3, pad
);
    import fcsp_pkg::*;

    logic                     r_in_valid;
    logic [OP_W-1:0]          r_in_op;
    logic [CHANNEL_W-1:0]     r_in_channel;
    logic [AMOUNT_W-1:0]      r_in_amount;

    logic                     r_out_valid;
    logic [OUT_TDATA_W-1:0]   r_out_data;

    logic [POS_W-1:0]         r_pos;
    logic [WIDTH_W-1:0]       r_width [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]  r_levels;

    logic [POS_W-1:0]         n_pos;
    logic [WIDTH_W-1:0]       n_width [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]  n_levels;
    logic [OUT_TDATA_W-1:0]   n_out_data;

    logic                     out_en;
    logic                     in_en;
    logic                     set_en;
    logic [WIDTH_W-1:0]       set_ticks;
    logic [POS_W-1:0]         pos_inc;

    assign out_en        = !r_out_valid || m_axis_tready;
    assign in_en         = !r_in_valid || out_en;
    assign s_axis_tready = in_en;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_pos     = r_pos;
        n_levels  = r_levels;
        n_width   = r_width;
        set_en    = 1'b0;
        set_ticks = us_to_ticks(r_in_amount);
        pos_inc   = r_pos + POS_W'(1);
        case (r_in_op)
            OP_TICK: begin
                if (r_pos == '0) begin
                    n_levels = '1;
                end
                for (int k = 0; k < NUM_CHANNELS; k++) begin
                    if (r_pos == POS_W'(r_width[k])) begin
                        n_levels[k] = 1'b0;
                    end
                end
                n_pos = (pos_inc >= POS_W'(FRAME_TICKS)) ? '0 : pos_inc;
            end
            OP_SET_US: begin
                set_en = 1'b1;
            end
            OP_SET_ANGLE: begin
                set_en    = 1'b1;
                set_ticks = angle_to_ticks(r_in_amount);
            end
            default: begin
                set_en = 1'b0;
            end
        endcase
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            if (set_en && r_in_channel == CHANNEL_W'(k)) begin
                n_width[k] = set_ticks;
            end
        end
        n_out_data = '0;
        for (int j = 0; j < OUT_FIELDS; j++) begin
            if (j < NUM_CHANNELS) begin
                n_out_data[j] = n_levels[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_levels    <= '0;
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_width[k] <= WIDTH_W'(RESET_WIDTH);
            end
        end else begin
            if (out_en) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_pos    <= n_pos;
                    r_levels <= n_levels;
                    r_width  <= n_width;
                end
            end
            if (in_en) begin
                r_in_valid <= s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_en) begin
            r_in_op      <= s_axis_tuser;
            r_in_channel <= s_axis_tdata[CHANNEL_W-1:0];
            r_in_amount  <= s_axis_tdata[CHANNEL_W +: AMOUNT_W];
        end
        if (out_en && r_in_valid) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// File: rtl/fcsp_checker.sv
// ----------------------------------------------------------------------------
// fcsp_checker
// Port-level checks for the servo pulse generator, bound to the top level.
// ----------------------------------------------------------------------------
module fcsp_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [fcsp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import fcsp_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // every accepted item shows up as a valid result after the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
        else $error("accepted item produced no result");

    // empty output slot never blocks the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:OUT_FIELDS] == '0)
        else $error("padding bits not zero");

    a_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind four_channel_servo_pwm fcsp_checker u_fcsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
